/* design/assert_macros.svh */
// Assertion macros used by the top level of the line junction arrival detector.
// Each macro expands to one labeled concurrent assertion on a rising clock edge,
// disabled while the asynchronous reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* design/ljad_pkg.sv */
// Package for the line junction arrival detector: shared types, constants and helpers.
// Used by ljad_eval and line_junction_arrival_detector; depends on nothing else.

package ljad_pkg;

    // Configuration register indexes.
    localparam logic CFG_CONDITIONS = 1'b0;
    localparam logic CFG_CONFIRM    = 1'b1;

    localparam logic [7:0] CONDITIONS_RESET = 8'd0;
    localparam logic [3:0] CONFIRM_RESET    = 4'd3;

    // Bits of the condition enable mask.
    localparam int COND_LEFT_BAR    = 0;
    localparam int COND_RIGHT_BAR   = 1;
    localparam int COND_LEFT_FORK   = 2;
    localparam int COND_RIGHT_FORK  = 3;
    localparam int COND_MULTI_SINGLE = 4;
    localparam int COND_MULTI_MULTI = 5;
    localparam int COND_ALL_SAME    = 6;
    localparam int COND_MORE_LIT    = 7;

    localparam logic [15:0] LEFT_FORK_MASK  = 16'h0180;
    localparam logic [15:0] RIGHT_FORK_MASK = 16'h0018;

    localparam logic [3:0] BAR_MIN_LIT     = 4'd5;
    localparam logic [4:0] FORK_LIT_LIMIT  = 5'd6;
    localparam logic [4:0] ALL_LIT_MIN     = 5'd14;
    localparam logic [4:0] MORE_LIT_MIN    = 5'd5;
    localparam logic [4:0] MULTI_LIT_MIN   = 5'd4;
    localparam logic [4:0] SINGLE_LIT_MAX  = 5'd3;

    // Operation codes of an input transaction.
    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    // Multi-line sequence phase.
    typedef enum logic [2:0] {
        PH_WAIT_MULTI  = 3'b001,
        PH_WAIT_SINGLE = 3'b010,
        PH_WAIT_MULTI2 = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] conditions;
        logic [3:0] confirm;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [15:0] sensor_bits;
        logic [4:0]  lit_count;
        logic [3:0]  line_count;
    } sample_t;

    typedef struct packed {
        logic [3:0] simple_run;
        logic [3:0] multi_run;
        phase_t     phase;
    } det_state_t;

    function automatic logic [3:0] count_bits8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    // Output encoding of the phase: 0 wait multi, 1 wait single, 2 wait multi again.
    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT_MULTI:  code = 2'd0;
            PH_WAIT_SINGLE: code = 2'd1;
            PH_WAIT_MULTI2: code = 2'd2;
            default:        code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

/* design/ljad_eval.sv */
// Per-sample evaluation of the junction detector: pattern tests, run counters
// and the multi-line phase sequence. Purely combinational; uses ljad_pkg.

module ljad_eval (
    input  ljad_pkg::cfg_t       cfg,
    input  ljad_pkg::sample_t    sample,
    input  ljad_pkg::det_state_t cur,
    output ljad_pkg::det_state_t nxt,
    output logic                 arrived
);
    import ljad_pkg::*;

    logic       left_bar;
    logic       right_bar;
    logic       left_fork;
    logic       right_fork;
    logic       all_same;
    logic       more_lit;
    logic       simple_hit;
    logic [3:0] simple_len;
    logic       is_multi;
    logic       is_single;
    logic       phase_cond;
    logic [3:0] phase_len;
    logic       phase_done;

    always_comb
    begin
        left_bar   = count_bits8(sample.sensor_bits[15:8]) >= BAR_MIN_LIT;
        right_bar  = count_bits8(sample.sensor_bits[7:0]) >= BAR_MIN_LIT;
        left_fork  = ((sample.sensor_bits & LEFT_FORK_MASK) == LEFT_FORK_MASK)
                     && (sample.lit_count < FORK_LIT_LIMIT);
        right_fork = ((sample.sensor_bits & RIGHT_FORK_MASK) == RIGHT_FORK_MASK)
                     && (sample.lit_count < FORK_LIT_LIMIT);
        all_same   = (sample.lit_count == 5'd0) || (sample.lit_count >= ALL_LIT_MIN);
        more_lit   = sample.lit_count >= MORE_LIT_MIN;

        simple_hit = (cfg.conditions[COND_LEFT_BAR]   && left_bar)
                  || (cfg.conditions[COND_RIGHT_BAR]  && right_bar)
                  || (cfg.conditions[COND_LEFT_FORK]  && left_fork)
                  || (cfg.conditions[COND_RIGHT_FORK] && right_fork)
                  || (cfg.conditions[COND_ALL_SAME]   && all_same)
                  || (cfg.conditions[COND_MORE_LIT]   && more_lit);

        if (simple_hit)
        begin
            simple_len = (cur.simple_run < cfg.confirm) ? cur.simple_run + 4'd1
                                                        : cur.simple_run;
        end
        else
        begin
            simple_len = 4'd0;
        end

        is_multi  = (sample.line_count > 4'd1) && (sample.lit_count >= MULTI_LIT_MIN);
        is_single = sample.line_count == 4'd1;

        // The condition that the current phase waits for.
        if (cfg.conditions[COND_MULTI_SINGLE])
        begin
            phase_cond = (cur.phase == PH_WAIT_MULTI) ? is_multi : is_single;
        end
        else if (cur.phase == PH_WAIT_SINGLE)
        begin
            phase_cond = is_single || (sample.lit_count <= SINGLE_LIT_MAX);
        end
        else
        begin
            phase_cond = is_multi;
        end

        if (phase_cond)
        begin
            phase_len = (cur.multi_run < cfg.confirm) ? cur.multi_run + 4'd1
                                                      : cur.multi_run;
        end
        else
        begin
            phase_len = 4'd0;
        end
        phase_done = phase_len >= cfg.confirm;

        nxt     = cur;
        arrived = 1'b0;

        if (sample.op == OP_CLEAR)
        begin
            nxt.simple_run = 4'd0;
            nxt.multi_run  = 4'd0;
            nxt.phase      = PH_WAIT_MULTI;
        end
        else if (simple_len >= cfg.confirm)
        begin
            // A confirmed simple pattern wins and the sequence logic sits out.
            nxt.simple_run = 4'd0;
            arrived        = 1'b1;
        end
        else
        begin
            nxt.simple_run = simple_len;
            if (cfg.conditions[COND_MULTI_SINGLE])
            begin
                nxt.multi_run = phase_done ? 4'd0 : phase_len;
                if (phase_done)
                begin
                    if (cur.phase == PH_WAIT_MULTI)
                    begin
                        nxt.phase = PH_WAIT_SINGLE;
                    end
                    else
                    begin
                        nxt.phase = PH_WAIT_MULTI;
                        arrived   = 1'b1;
                    end
                end
            end
            else if (cfg.conditions[COND_MULTI_MULTI])
            begin
                unique case (cur.phase)
                    PH_WAIT_MULTI:
                    begin
                        nxt.multi_run = phase_done ? 4'd0 : phase_len;
                        if (phase_done)
                        begin
                            nxt.phase = PH_WAIT_SINGLE;
                        end
                    end
                    PH_WAIT_SINGLE:
                    begin
                        nxt.multi_run = phase_done ? 4'd0 : phase_len;
                        if (phase_done)
                        begin
                            nxt.phase = PH_WAIT_MULTI2;
                        end
                    end
                    PH_WAIT_MULTI2:
                    begin
                        nxt.multi_run = phase_done ? 4'd0 : phase_len;
                        if (phase_done)
                        begin
                            nxt.phase = PH_WAIT_MULTI;
                            arrived   = 1'b1;
                        end
                    end
                    default:
                    begin
                        // A corrupt phase restarts the whole detector.
                        nxt.simple_run = 4'd0;
                        nxt.multi_run  = 4'd0;
                        nxt.phase      = PH_WAIT_MULTI;
                    end
                endcase
            end
        end
    end

endmodule

/* design/line_junction_arrival_detector.sv */
// Top level of the line junction arrival detector: input register, detector
// state and result register around ljad_eval. Uses ljad_pkg and assert_macros.svh.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one tracker sample per transaction:
//   op selects evaluate or clear; sensor_bits, lit_count and line_count describe it.
// - Output channel (out_valid/out_ready) returns exactly one result per input
//   transaction: arrived and the multi-line phase after that sample.
// - Configuration: cfg_we writes cfg_data into register cfg_index (0 condition
//   mask, 1 confirm count) at the next edge; write only while the block is empty.
// - Path: an accepted sample waits in the input register and moves through the
//   evaluation stage into the result register once that register is free.
// - Throughput: one sample per cycle unless stalled; the detector state is read and
//   updated in the single evaluation stage between the input and result registers.
// - When the receiver stalls, the result register holds, then the input register
//   fills, and in_ready drops; nothing is lost and the state waits with them.
// - Reset clears both stages, the run counters and the phase, sets the condition
//   mask to 0 and the confirm count to 3.

module line_junction_arrival_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] sensor_bits,
    input  logic [4:0]  lit_count,
    input  logic [3:0]  line_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        arrived,
    output logic [1:0]  sequence_phase,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import ljad_pkg::*;

    `include "assert_macros.svh"

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       s1_valid_reg;
    sample_t    s1_sample_reg;
    det_state_t state_reg;
    det_state_t state_next;
    logic       eval_arrived;
    logic       out_valid_reg;
    logic       arrived_reg;
    logic [1:0] phase_out_reg;
    logic       s2_load;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONDITIONS: cfg_next.conditions = cfg_data;
                CFG_CONFIRM:    cfg_next.confirm    = cfg_data[3:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    ljad_eval u_eval (
        .cfg     (cfg_reg),
        .sample  (s1_sample_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .arrived (eval_arrived)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conditions <= CONDITIONS_RESET;
            cfg_reg.confirm    <= CONFIRM_RESET;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.simple_run <= 4'd0;
            state_reg.multi_run  <= 4'd0;
            state_reg.phase      <= PH_WAIT_MULTI;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg.op          <= op;
            s1_sample_reg.sensor_bits <= sensor_bits;
            s1_sample_reg.lit_count   <= lit_count;
            s1_sample_reg.line_count  <= line_count;
        end
        if (s2_load)
        begin
            arrived_reg   <= eval_arrived;
            phase_out_reg <= phase_code(state_next.phase);
        end
    end

    assign out_valid      = out_valid_reg;
    assign arrived        = arrived_reg;
    assign sequence_phase = phase_out_reg;

    `ASSERT_SAME(a_phase_onehot, clk, rst_n, 1'b1, $onehot(state_reg.phase))
    `ASSERT_SAME(a_stall_holds_input, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg)
    `ASSERT_NEXT(a_clear_result, clk, rst_n, s2_load && (s1_sample_reg.op == OP_CLEAR),
                 !arrived_reg && (phase_out_reg == 2'd0) && (state_reg.simple_run == 4'd0))
    `ASSERT_SAME(a_phase_matches_state, clk, rst_n, out_valid_reg,
                 phase_out_reg == phase_code(state_reg.phase))

endmodule

/* sim/line_junction_arrival_detector_tb.sv */
// Self-checking testbench for the line junction arrival detector.
// Depends on ljad_pkg and the line_junction_arrival_detector top level; a built-in
// predictor of the run counters and the multi-line phase checks every result.
`timescale 1ns / 1ps

module line_junction_arrival_detector_tb;

    import ljad_pkg::*;

    localparam logic [1:0] PHASE_WAIT_MULTI  = 2'd0;
    localparam logic [1:0] PHASE_WAIT_SINGLE = 2'd1;
    localparam logic [1:0] PHASE_WAIT_MULTI2 = 2'd2;

    typedef struct packed {
        logic       arrived;
        logic [1:0] phase;
    } junction_result_t;

    typedef enum {
        KIND_MULTI,
        KIND_SINGLE,
        KIND_LOW_LIT,
        KIND_BAR,
        KIND_FORK,
        KIND_NOISE
    } sample_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [15:0] sensor_bits;
    logic [4:0]  lit_count;
    logic [3:0]  line_count;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        arrived;
    logic [1:0]  sequence_phase;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // Predictor copy of the configuration and the detector state.
    logic [7:0] cond_mask    = CONDITIONS_RESET;
    logic [3:0] confirm_cnt  = CONFIRM_RESET;
    logic [3:0] simple_run_q = 4'd0;
    logic [3:0] multi_run_q  = 4'd0;
    logic [1:0] seq_phase    = PHASE_WAIT_MULTI;

    junction_result_t expected_arrivals[$];
    junction_result_t next_expected;
    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    line_junction_arrival_detector u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sensor_bits    (sensor_bits),
        .lit_count      (lit_count),
        .line_count     (line_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .arrived        (arrived),
        .sequence_phase (sequence_phase),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic simple_match(input logic [15:0] bits, input logic [4:0] lit);
        logic hit;
        hit = 1'b0;
        if (cond_mask[COND_LEFT_BAR] && $countones(bits[15:8]) >= int'(BAR_MIN_LIT))
            hit = 1'b1;
        if (cond_mask[COND_RIGHT_BAR] && $countones(bits[7:0]) >= int'(BAR_MIN_LIT))
            hit = 1'b1;
        if (cond_mask[COND_LEFT_FORK] && (bits & LEFT_FORK_MASK) == LEFT_FORK_MASK
                && lit < FORK_LIT_LIMIT)
            hit = 1'b1;
        if (cond_mask[COND_RIGHT_FORK] && (bits & RIGHT_FORK_MASK) == RIGHT_FORK_MASK
                && lit < FORK_LIT_LIMIT)
            hit = 1'b1;
        if (cond_mask[COND_ALL_SAME] && (lit == 5'd0 || lit >= ALL_LIT_MIN))
            hit = 1'b1;
        if (cond_mask[COND_MORE_LIT] && lit >= MORE_LIT_MIN)
            hit = 1'b1;
        return hit;
    endfunction

    // Every phase of the multi-line sequence needs its own run of true samples.
    function automatic logic run_confirmed(input logic cond);
        if (cond)
        begin
            if (multi_run_q < confirm_cnt)
                multi_run_q = multi_run_q + 4'd1;
        end
        else
        begin
            multi_run_q = 4'd0;
        end
        if (multi_run_q < confirm_cnt)
            return 1'b0;
        multi_run_q = 4'd0;
        return 1'b1;
    endfunction

    function automatic logic sequence_step(input logic [4:0] lit, input logic [3:0] lines);
        logic multi;
        logic done;
        multi = (lines > 4'd1) && (lit >= MULTI_LIT_MIN);
        done = 1'b0;
        if (cond_mask[COND_MULTI_SINGLE])
        begin
            if (seq_phase == PHASE_WAIT_MULTI)
            begin
                if (run_confirmed(multi))
                    seq_phase = PHASE_WAIT_SINGLE;
            end
            else if (run_confirmed(lines == 4'd1))
            begin
                seq_phase = PHASE_WAIT_MULTI;
                done = 1'b1;
            end
        end
        else if (cond_mask[COND_MULTI_MULTI])
        begin
            case (seq_phase)
                PHASE_WAIT_MULTI:
                begin
                    if (run_confirmed(multi))
                        seq_phase = PHASE_WAIT_SINGLE;
                end
                PHASE_WAIT_SINGLE:
                begin
                    if (run_confirmed(lines == 4'd1 || lit <= SINGLE_LIT_MAX))
                        seq_phase = PHASE_WAIT_MULTI2;
                end
                PHASE_WAIT_MULTI2:
                begin
                    if (run_confirmed(multi))
                    begin
                        seq_phase = PHASE_WAIT_MULTI;
                        done = 1'b1;
                    end
                end
                default:
                begin
                    simple_run_q = 4'd0;
                    multi_run_q = 4'd0;
                    seq_phase = PHASE_WAIT_MULTI;
                end
            endcase
        end
        return done;
    endfunction

    task automatic predict_arrival(input logic op_i, input logic [15:0] bits,
                                   input logic [4:0] lit, input logic [3:0] lines);
        junction_result_t r;
        r.arrived = 1'b0;
        if (op_i == OP_CLEAR)
        begin
            simple_run_q = 4'd0;
            multi_run_q = 4'd0;
            seq_phase = PHASE_WAIT_MULTI;
        end
        else
        begin
            if (simple_match(bits, lit))
            begin
                if (simple_run_q < confirm_cnt)
                    simple_run_q = simple_run_q + 4'd1;
            end
            else
            begin
                simple_run_q = 4'd0;
            end
            // A confirmed simple pattern skips the multi-line logic on this sample.
            if (simple_run_q >= confirm_cnt)
            begin
                simple_run_q = 4'd0;
                r.arrived = 1'b1;
            end
            else
            begin
                r.arrived = sequence_step(lit, lines);
            end
        end
        r.phase = seq_phase;
        expected_arrivals.push_back(r);
    endtask

    task automatic send_sample(input logic op_i, input logic [15:0] bits,
                               input logic [4:0] lit, input logic [3:0] lines);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_i;
        sensor_bits <= bits;
        lit_count   <= lit;
        line_count  <= lines;
        do
            @(posedge clk);
        while (!in_ready);
        predict_arrival(op_i, bits, lit, lines);
    endtask

    task automatic send_of_kind(input sample_kind_t kind);
        logic [15:0] bits;
        logic [4:0]  lit;
        logic [3:0]  lines;
        bits  = 16'($urandom);
        lit   = 5'($urandom);
        lines = 4'($urandom);
        case (kind)
            KIND_MULTI:
            begin
                lit   = 5'($urandom_range(4, 16));
                lines = 4'($urandom_range(2, 8));
            end
            KIND_SINGLE:
            begin
                lit   = 5'($urandom_range(1, 6));
                lines = 4'd1;
            end
            KIND_LOW_LIT:
            begin
                lit   = 5'($urandom_range(0, 3));
                lines = 4'($urandom_range(0, 3));
            end
            KIND_BAR:
            begin
                bits  = bits | ($urandom_range(0, 1) ? 16'hF800 : 16'h001F);
                lit   = 5'($urandom_range(5, 16));
                lines = 4'($urandom_range(1, 3));
            end
            KIND_FORK:
            begin
                bits  = bits | ($urandom_range(0, 1) ? LEFT_FORK_MASK : RIGHT_FORK_MASK);
                lit   = 5'($urandom_range(2, 7));
                lines = 4'($urandom_range(1, 3));
            end
            default:
            begin
            end
        endcase
        send_sample(OP_EVALUATE, bits, lit, lines);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_arrivals.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] cond, input logic [7:0] confirm_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CONDITIONS;
        cfg_data  <= cond;
        @(posedge clk);
        cfg_index <= CFG_CONFIRM;
        cfg_data  <= confirm_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cond_mask   = cond;
        confirm_cnt = confirm_data[3:0];
    endtask

    task automatic test_reset_config();
        // Nothing is enabled after reset, so no sample may arrive.
        send_sample(OP_EVALUATE, 16'hFFFF, 5'd16, 4'd1);
        send_sample(OP_EVALUATE, 16'h0000, 5'd0, 4'd0);
        send_sample(OP_EVALUATE, 16'h0F0F, 5'd8, 4'd2);
    endtask

    task automatic test_simple_patterns();
        wait_for_results();
        apply_config(8'hCF, 8'd1);
        send_sample(OP_EVALUATE, 16'hF800, 5'd5, 4'd1);
        send_sample(OP_EVALUATE, 16'h001F, 5'd5, 4'd1);
        send_sample(OP_EVALUATE, 16'h0180, 5'd2, 4'd2);
        send_sample(OP_EVALUATE, 16'h0018, 5'd2, 4'd2);
        send_sample(OP_EVALUATE, 16'h0000, 5'd0, 4'd0);
        send_sample(OP_EVALUATE, 16'hFFFF, 5'd16, 4'd1);
        send_sample(OP_EVALUATE, 16'h0000, 5'd31, 4'd15);
        send_sample(OP_EVALUATE, 16'h0001, 5'd1, 4'd1);
    endtask

    task automatic test_zero_confirm();
        wait_for_results();
        apply_config(8'h00, 8'd0);
        send_sample(OP_EVALUATE, 16'h0000, 5'd1, 4'd1);
        send_sample(OP_CLEAR, 16'hFFFF, 5'd16, 4'd8);
        send_sample(OP_EVALUATE, 16'h8001, 5'd2, 4'd2);
    endtask

    task automatic test_multi_to_single();
        wait_for_results();
        apply_config(8'h10, 8'd2);
        send_sample(OP_EVALUATE, 16'h0F0F, 5'd8, 4'd2);
        send_sample(OP_EVALUATE, 16'h3333, 5'd8, 4'd4);
        send_sample(OP_EVALUATE, 16'h0180, 5'd2, 4'd1);
        send_sample(OP_EVALUATE, 16'h0180, 5'd2, 4'd1);
    endtask

    task automatic test_multi_to_multi();
        wait_for_results();
        apply_config(8'h20, 8'd1);
        send_sample(OP_EVALUATE, 16'hF00F, 5'd8, 4'd2);
        send_sample(OP_EVALUATE, 16'h0007, 5'd3, 4'd0);
        send_sample(OP_EVALUATE, 16'hC003, 5'd4, 4'd2);
        send_sample(OP_EVALUATE, 16'hC003, 5'd4, 4'd3);
        send_sample(OP_CLEAR, 16'h0000, 5'd0, 4'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        int           setting;
        int           per_setting;
        int           sent;
        int           pick;
        int           run;
        sample_kind_t kind;
        logic [7:0]   cond;
        logic [3:0]   confirm;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        per_setting = n_items / 6;
        for (setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0:
                begin
                    cond = 8'hFF;
                    confirm = 4'd15;
                end
                1:
                begin
                    cond = 8'h10;
                    confirm = 4'($urandom_range(1, 4));
                end
                2:
                begin
                    cond = 8'h20;
                    confirm = 4'($urandom_range(1, 4));
                end
                3:
                begin
                    cond = 8'($urandom);
                    confirm = 4'd0;
                end
                4:
                begin
                    cond = 8'($urandom) | 8'h30;
                    confirm = 4'($urandom_range(1, 3));
                end
                default:
                begin
                    cond = 8'h00;
                    confirm = 4'($urandom_range(1, 15));
                end
            endcase
            wait_for_results();
            // The upper data bits have no register behind them and must be dropped.
            apply_config(cond, {4'($urandom), confirm});
            sent = 0;
            while (sent < per_setting)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    send_sample(OP_CLEAR, 16'($urandom), 5'($urandom), 4'($urandom));
                    sent++;
                end
                else
                begin
                    if (pick < 15)
                        kind = KIND_NOISE;
                    else if (pick < 45)
                        kind = KIND_MULTI;
                    else if (pick < 65)
                        kind = KIND_SINGLE;
                    else if (pick < 75)
                        kind = KIND_LOW_LIT;
                    else if (pick < 87)
                        kind = KIND_BAR;
                    else
                        kind = KIND_FORK;
                    // Runs of one kind let the confirm counters reach their limit.
                    run = $urandom_range(1, int'(confirm_cnt) + 2);
                    repeat (run)
                    begin
                        send_of_kind(kind);
                        sent++;
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_arrivals.size() == 0)
            begin
                $display("time %0t: unexpected transaction, expected none, actual %0b %0d",
                         $time, arrived, sequence_phase);
                error_count++;
            end
            else
            begin
                next_expected = expected_arrivals.pop_front();
                if (arrived !== next_expected.arrived)
                begin
                    $display("time %0t: arrived mismatch, expected %0b, actual %0b",
                             $time, next_expected.arrived, arrived);
                    error_count++;
                end
                if (sequence_phase !== next_expected.phase)
                begin
                    $display("time %0t: sequence_phase mismatch, expected %0d, actual %0d",
                             $time, next_expected.phase, sequence_phase);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_EVALUATE;
        sensor_bits <= 16'h0000;
        lit_count   <= 5'd0;
        line_count  <= 4'd0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_CONDITIONS;
        cfg_data    <= 8'h00;
        send_idle_pct = 24;
        recv_idle_pct = 49;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_simple_patterns();
        test_zero_confirm();
        test_multi_to_single();
        test_multi_to_multi();
        test_random_traffic(316, 24, 49);
        test_random_traffic(316, 49, 24);
        test_random_traffic(318, 0, 0);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
